// ===== rtl/epcal_pkg.sv =====
// Package for the epoch seconds to calendar converter.
// Holds calendar constants and the month length function; depends on nothing.
package epcal_pkg;

    localparam int unsigned EPOCH_YEAR = 1970;
    localparam int unsigned SECS_PER_DAY = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN = 60;
    localparam logic signed [4:0] RESET_OFFSET = 5'sd8;

    // Bit m is set for the months of 31 days, January is bit 0.
    localparam logic [11:0] LONG_MONTH = 12'hAD5;

    typedef logic [4:0] month_len_t;

    function automatic month_len_t month_len(input logic [3:0] m, input logic leap);
        month_len_t len;
        if (m == 4'd1) begin
            len = leap ? 5'd29 : 5'd28;
        end else begin
            len = LONG_MONTH[m] ? 5'd31 : 5'd30;
        end
        return len;
    endfunction

endpackage

// ===== rtl/epoch_seconds_to_calendar.sv =====
// Epoch seconds to calendar date and time of day with a whole-hour offset; uses epcal_pkg.
// A single shared compare-subtract unit runs divides, then year and month stepping.
// Steps after input accept: day, hour and minute divides, then year stepping over the Y
// whole years past 1970 (up to 136) and month stepping to month index M (up to 11).
// A new item is accepted only after the last one finishes, later while a result waits.
// Synchronous active-low reset clears control state and sets the offset to +8 hours.
module epoch_seconds_to_calendar
    import epcal_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_epoch_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_year,
    output logic [3:0]  m_month,
    output logic [4:0]  m_day_of_month,
    output logic [4:0]  m_hour,
    output logic [5:0]  m_minute,
    output logic [5:0]  m_second
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DAY   = 3'd1;
    localparam logic [2:0] ST_HOUR  = 3'd2;
    localparam logic [2:0] ST_MIN   = 3'd3;
    localparam logic [2:0] ST_YEAR  = 3'd4;
    localparam logic [2:0] ST_MONTH = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    localparam logic signed [12:0] HOUR_SECS_S = 13'(SECS_PER_HOUR);

    logic [2:0]         state_reg, state_next;
    logic signed [4:0]  offset_reg, offset_next;
    logic [32:0]        acc_reg, acc_next;
    logic [3:0]         k_reg, k_next;
    logic [15:0]        q_reg, q_next;
    logic [15:0]        days_reg, days_next;
    logic [4:0]         hour_reg, hour_next;
    logic [5:0]         minute_reg, minute_next;
    logic [5:0]         second_reg, second_next;
    logic [11:0]        year_reg, year_next;
    logic [6:0]         mod100_reg, mod100_next;
    logic [8:0]         mod400_reg, mod400_next;
    logic [3:0]         month_reg, month_next;
    logic               m_valid_reg, m_valid_next;
    logic [11:0]        o_year_reg, o_year_next;
    logic [3:0]         o_month_reg, o_month_next;
    logic [4:0]         o_day_reg, o_day_next;
    logic [4:0]         o_hour_reg, o_hour_next;
    logic [5:0]         o_minute_reg, o_minute_next;
    logic [5:0]         o_second_reg, o_second_next;

    logic signed [17:0] off_secs;
    logic signed [33:0] shifted;
    logic               leap;
    logic [32:0]        sub_op;
    logic [33:0]        diff;
    logic               ge;
    logic [15:0]        q_shift;
    logic               out_free;

    assign off_secs = offset_reg * HOUR_SECS_S;
    assign shifted = $signed({2'b00, s_epoch_seconds}) + 34'(off_secs);
    assign leap = ((year_reg[1:0] == 2'd0) && (mod100_reg != 7'd0)) || (mod400_reg == 9'd0);

    always_comb begin
        case (state_reg)
            ST_DAY:   sub_op = 33'(SECS_PER_DAY) << k_reg;
            ST_HOUR:  sub_op = 33'(SECS_PER_HOUR) << k_reg;
            ST_MIN:   sub_op = 33'(SECS_PER_MIN) << k_reg;
            ST_YEAR:  sub_op = leap ? 33'd366 : 33'd365;
            ST_MONTH: sub_op = 33'(month_len(month_reg, leap));
            default:  sub_op = '0;
        endcase
    end

    assign diff = {1'b0, acc_reg} - {1'b0, sub_op};
    assign ge = !diff[33];
    assign q_shift = {q_reg[14:0], ge};
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        offset_next = offset_reg;
        acc_next = acc_reg;
        k_next = k_reg;
        q_next = q_reg;
        days_next = days_reg;
        hour_next = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        year_next = year_reg;
        mod100_next = mod100_reg;
        mod400_next = mod400_reg;
        month_next = month_reg;
        m_valid_next = m_valid_reg && !m_ready;
        o_year_next = o_year_reg;
        o_month_next = o_month_reg;
        o_day_next = o_day_reg;
        o_hour_next = o_hour_reg;
        o_minute_next = o_minute_reg;
        o_second_next = o_second_reg;

        if (cfg_wr_en) begin
            offset_next = $signed(cfg_wr_data);
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    acc_next = shifted[33] ? 33'd0 : shifted[32:0];
                    k_next = 4'd15;
                    q_next = '0;
                    state_next = ST_DAY;
                end
            end
            ST_DAY, ST_HOUR, ST_MIN: begin
                if (ge) begin
                    acc_next = diff[32:0];
                end
                q_next = q_shift;
                k_next = k_reg - 4'd1;
                if (k_reg == 4'd0) begin
                    q_next = '0;
                    if (state_reg == ST_DAY) begin
                        days_next = q_shift;
                        k_next = 4'd4;
                        state_next = ST_HOUR;
                    end else if (state_reg == ST_HOUR) begin
                        hour_next = q_shift[4:0];
                        k_next = 4'd5;
                        state_next = ST_MIN;
                    end else begin
                        minute_next = q_shift[5:0];
                        second_next = ge ? diff[5:0] : acc_reg[5:0];
                        acc_next = {17'd0, days_reg};
                        year_next = 12'(EPOCH_YEAR);
                        mod100_next = 7'(EPOCH_YEAR % 100);
                        mod400_next = 9'(EPOCH_YEAR % 400);
                        state_next = ST_YEAR;
                    end
                end
            end
            ST_YEAR: begin
                if (ge) begin
                    acc_next = diff[32:0];
                    year_next = year_reg + 12'd1;
                    mod100_next = (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
                    mod400_next = (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
                end else begin
                    month_next = 4'd0;
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if ((month_reg < 4'd11) && ge) begin
                    acc_next = diff[32:0];
                    month_next = month_reg + 4'd1;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    o_year_next = year_reg;
                    o_month_next = month_reg + 4'd1;
                    o_day_next = acc_reg[4:0] + 5'd1;
                    o_hour_next = hour_reg;
                    o_minute_next = minute_reg;
                    o_second_next = second_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            offset_reg <= RESET_OFFSET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            offset_reg <= offset_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        k_reg <= k_next;
        q_reg <= q_next;
        days_reg <= days_next;
        hour_reg <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
        year_reg <= year_next;
        mod100_reg <= mod100_next;
        mod400_reg <= mod400_next;
        month_reg <= month_next;
        o_year_reg <= o_year_next;
        o_month_reg <= o_month_next;
        o_day_reg <= o_day_next;
        o_hour_reg <= o_hour_next;
        o_minute_reg <= o_minute_next;
        o_second_reg <= o_second_next;
    end

    assign m_valid = m_valid_reg;
    assign m_year = o_year_reg;
    assign m_month = o_month_reg;
    assign m_day_of_month = o_day_reg;
    assign m_hour = o_hour_reg;
    assign m_minute = o_minute_reg;
    assign m_second = o_second_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("Input accepted again while a conversion was starting.");

    a_days_narrow_in_year: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_YEAR) |-> (acc_reg[32:16] == 17'd0))
        else $error("Day count out of range during year stepping.");

    a_month_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MONTH) |-> (month_reg <= 4'd11))
        else $error("Month index out of range.");

    a_result_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_month >= 4'd1) && (m_month <= 4'd12) && (m_day_of_month != 5'd0)
                     && (m_hour <= 5'd23) && (m_minute <= 6'd59) && (m_second <= 6'd59)))
        else $error("Result item holds a field out of range.");

endmodule

// ===== test/calendar_sb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the epoch seconds to calendar converter testbench.
// Predicts each calendar stamp from the accepted seconds count and checks results in order.
// Depends on epcal_pkg for the calendar constants and the reset offset.
package calendar_sb_pkg;
    import epcal_pkg::*;

    typedef struct packed {
        logic [31:0] epoch;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } calendar_stamp_t;

    class calendar_scoreboard;
        logic signed [4:0] zone_hours;
        calendar_stamp_t   awaited[$];
        int unsigned       errors;

        function new();
            zone_hours = RESET_OFFSET;
            errors = 0;
        endfunction

        function void set_zone(logic signed [4:0] h);
            zone_hours = h;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void report(string msg);
            // Keep the log readable when the block is badly broken.
            if (errors < 200) begin
                $display("MISMATCH: %s", msg);
            end
            errors++;
        endfunction

        function bit is_leap(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int unsigned days_in_month(int unsigned mo, bit leap);
            int unsigned n;
            case (mo)
                1: begin
                    n = leap ? 29 : 28;
                end
                3, 5, 8, 10: begin
                    n = 30;
                end
                default: begin
                    n = 31;
                end
            endcase
            return n;
        endfunction

        function calendar_stamp_t convert(logic [31:0] secs);
            calendar_stamp_t r;
            longint shifted;
            longint unsigned t;
            longint unsigned days;
            int unsigned rem;
            int unsigned yr;
            int unsigned mo;
            shifted = longint'(secs) + longint'(zone_hours) * 64'sd3600;
            t = (shifted < 0) ? 64'd0 : shifted;
            days = t / SECS_PER_DAY;
            rem = 32'(t % SECS_PER_DAY);
            yr = EPOCH_YEAR;
            while (days >= (is_leap(yr) ? 366 : 365)) begin
                days -= is_leap(yr) ? 366 : 365;
                yr++;
            end
            mo = 0;
            while (mo < 11 && days >= days_in_month(mo, is_leap(yr))) begin
                days -= days_in_month(mo, is_leap(yr));
                mo++;
            end
            r.epoch = secs;
            r.year = yr[11:0];
            r.month = 4'(mo + 1);
            r.mday = 5'(days + 1);
            r.hour = 5'(rem / SECS_PER_HOUR);
            r.minute = 6'((rem % SECS_PER_HOUR) / SECS_PER_MIN);
            r.second = 6'(rem % SECS_PER_MIN);
            return r;
        endfunction

        function void note_input(logic [31:0] secs);
            awaited.push_back(convert(secs));
        endfunction

        function void check_result(logic [11:0] year, logic [3:0] month, logic [4:0] mday,
                                   logic [4:0] hour, logic [5:0] minute, logic [5:0] second);
            calendar_stamp_t e;
            if (awaited.size() == 0) begin
                report($sformatf("result %0d-%0d-%0d %0d:%0d:%0d with no item outstanding",
                                 year, month, mday, hour, minute, second));
                return;
            end
            e = awaited.pop_front();
            if (year !== e.year || month !== e.month || mday !== e.mday ||
                hour !== e.hour || minute !== e.minute || second !== e.second) begin
                report({$sformatf("epoch %0d zone %0d: got %0d-%0d-%0d %0d:%0d:%0d, ",
                                  e.epoch, zone_hours, year, month, mday,
                                  hour, minute, second),
                        $sformatf("expected %0d-%0d-%0d %0d:%0d:%0d",
                                  e.year, e.month, e.mday, e.hour, e.minute, e.second)});
            end
        endfunction
    endclass

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Top-level testbench for epoch_seconds_to_calendar: drives seconds counts and offsets.
// Depends on epcal_pkg, calendar_sb_pkg and the converter RTL.
module tb_top
    import epcal_pkg::*, calendar_sb_pkg::*;
();

    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEMS_PER_PHASE = 200;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [4:0]  cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_epoch_seconds = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [11:0] m_year;
    logic [3:0]  m_month;
    logic [4:0]  m_day_of_month;
    logic [4:0]  m_hour;
    logic [5:0]  m_minute;
    logic [5:0]  m_second;

    bit          calm = 1'b0;
    int          hold_asked = 0;
    int          hold_served = 0;
    int          cycles = 0;

    calendar_scoreboard sb = new();

    epoch_seconds_to_calendar uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_epoch_seconds (s_epoch_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_year          (m_year),
        .m_month         (m_month),
        .m_day_of_month  (m_day_of_month),
        .m_hour          (m_hour),
        .m_minute        (m_minute),
        .m_second        (m_second)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_year, m_month, m_day_of_month, m_hour, m_minute, m_second);
        end
    end

    // The receiver stalls at random, is always ready while calm, or, on request, holds off for a long stretch.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_asked != hold_served) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_served++;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 26);
            end
        end
    end

    task send_item(input logic [31:0] secs);
        while (!calm && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_epoch_seconds <= secs;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(secs);
    endtask

    task drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task write_zone(input logic signed [4:0] h);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= h;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_zone(h);
    endtask

    function logic [31:0] near_midnight();
        longint v;
        v = longint'($urandom_range(0, 49710)) * 86400 - longint'(sb.zone_hours) * 3600
            + longint'($urandom_range(0, 4)) - 2;
        return v[31:0];
    endfunction

    function logic [31:0] random_epoch();
        int unsigned k;
        logic [31:0] v;
        k = $urandom_range(99);
        if (k < 40) begin
            v = $urandom();
        end else if (k < 55) begin
            v = $urandom_range(0, 60000);
        end else if (k < 65) begin
            v = 32'hFFFF_FFFF - $urandom_range(0, 100000);
        end else begin
            v = near_midnight();
        end
        return v;
    endfunction

    initial begin
        logic [31:0] at_reset_zone[10] = '{32'd0, 32'd1, 32'd86399, 32'd94694399,
                                           32'd946684799, 32'd951782400, 32'd2147483647,
                                           32'd2147483648, 32'd4107542399, 32'hFFFF_FFFF};
        logic [31:0] at_utc[5] = '{32'd946684799, 32'd946684800, 32'd951868799,
                                   32'd4107542399, 32'd4107542400};
        logic signed [4:0] zones[6] = '{-5'sd12, 5'sd14, 5'sd0, -5'sd16, 5'sd15, 5'sd0};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Leap days, century years and the ends of the range, first at the reset offset.
        foreach (at_reset_zone[i]) send_item(at_reset_zone[i]);
        drain();
        write_zone(5'sd0);
        foreach (at_utc[i]) send_item(at_utc[i]);
        drain();
        // The most negative offset pushes the first hours before the epoch.
        write_zone(-5'sd16);
        send_item(32'd0);
        send_item(32'd57599);
        send_item(32'd57600);
        drain();
        write_zone(5'sd15);
        send_item(32'hFFFF_FFFF);
        drain();

        foreach (zones[p]) begin
            if (p == $size(zones) - 1) begin
                write_zone(5'($urandom_range(0, 31)));
            end else begin
                write_zone(zones[p]);
            end
            calm = (p == 2);
            if (p == 1) begin
                hold_asked++;
            end
            repeat (ITEMS_PER_PHASE) send_item(random_epoch());
            drain();
        end
        calm = 1'b0;

        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== epoch_seconds_to_calendar.f =====
rtl/epcal_pkg.sv
rtl/epoch_seconds_to_calendar.sv
test/calendar_sb_pkg.sv
test/tb_top.sv
